@@ hdl/fzn_pkg.sv @@
// package for the feature z-score normaliser
// holds payload structs, operation and status codes and sizing constants
// no dependencies
package fzn_pkg;

  localparam int unsigned DEF_MAX_FEATURES = 64;
  localparam int unsigned MAX_EXAMPLES     = 4095;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned SIG_W   = 23;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned NF_W    = 7;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned SSQ_W   = 60;
  localparam int unsigned PROD_W  = 72;
  localparam int unsigned DSR_W   = 24;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned MAG_W   = 36;
  localparam int unsigned VAR_W   = 46;

  localparam logic CFG_NUM_FEATURES  = 1'b0;
  localparam logic CFG_NORM_NOMINAL  = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_FINAL = 2'd2,
    OP_NORM  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_COUNT_SAT = 2'd2,
    ST_OUT_SAT   = 2'd3
  } status_e;

  typedef struct packed {
    op_e                     operation;
    logic [IDX_W-1:0]        feature_index;
    logic signed [VAL_W-1:0] feature_value;
    logic                    example_usable;
    logic                    last_element;
    logic                    nominal_feature;
  } fzn_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [SIG_W-1:0]        result_sigma;
    logic [IDX_W-1:0]        result_index;
    logic                    last_result;
    status_e                 status;
  } fzn_out_t;

endpackage

@@ hdl/fzn_stream_if.sv @@
// valid/ready stream interface carrying one payload beat
// payload type is handed in as a type parameter, no other dependencies
interface fzn_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/feature_zscore_normalizer_unit.sv @@
// feature z-score normaliser: one item at a time, ready only while idle
// clear emits directly, accumulate updates its entry, normalise runs a 38-step
// serial divide, finalise per feature 37- and 72-step divides, two shift-add
// products, a 23-step root; results leave through a one-beat output register
// rst_ni resets control, count and config at once; sums and stats read as zero
// through per-entry valid bits, so no clearing pass follows reset
module feature_zscore_normalizer_unit import fzn_pkg::*; #(
  parameter int unsigned MAX_FEATURES = DEF_MAX_FEATURES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fzn_stream_if.sink        in_i,
  fzn_stream_if.source      out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [NF_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned AW_ACC = SUM_W + SSQ_W;
  localparam int unsigned AW_STAT = VAL_W + SIG_W;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_ACC_WR   = 13'b0000000000010,
    S_FIN_RD   = 13'b0000000000100,
    S_FIN_LOAD = 13'b0000000001000,
    S_FIN_MEAN = 13'b0000000010000,
    S_FIN_MUL1 = 13'b0000000100000,
    S_FIN_MUL2 = 13'b0000001000000,
    S_FIN_VDIV = 13'b0000010000000,
    S_FIN_SQRT = 13'b0000100000000,
    S_FIN_WR   = 13'b0001000000000,
    S_NRM_LOAD = 13'b0010000000000,
    S_NRM_DIV  = 13'b0100000000000,
    S_EMIT     = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [47:0]       sq_q, sq_d;
  logic [NF_W-1:0]   feat_q, feat_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DSR_W-1:0]  n2_q, n2_d;
  logic [NF_W-1:0]   cfg_nf_q;
  logic              cfg_nnom_q;
  logic              neg_q, neg_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [SSQ_W-1:0]  ssq_q, ssq_d;
  logic [PROD_W-1:0] p1_q, p1_d;
  logic [VAL_W-1:0]  mean_q, mean_d;
  logic [SIG_W-1:0]  sigma_q, sigma_d;
  status_e           st_q, st_d;
  fzn_out_t          res_q, res_d, out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [NF_W-1:0]   nf;
  logic              in_fire;
  fzn_in_t           p;
  logic [VAL_W-1:0]  vmag;

  logic              acc_clr, acc_we, acc_re;
  logic [AW-1:0]     acc_waddr, acc_raddr;
  logic [AW_ACC-1:0] acc_wdata, acc_rdata;
  logic              stat_we, stat_re;
  logic [AW-1:0]     stat_waddr, stat_raddr;
  logic [AW_STAT-1:0] stat_wdata, stat_rdata;

  logic              div_start, div_busy, div_done;
  logic [PROD_W-1:0] div_dvd, div_quo;
  logic [DSR_W-1:0]  div_dsr;
  logic [LEN_W-1:0]  div_len;
  logic              mul_start, mul_busy, mul_done;
  logic [PROD_W-1:0] mul_a, mul_prod;
  logic [MAG_W-1:0]  mul_b;
  logic              sqrt_start, sqrt_busy, sqrt_done;
  logic [VAR_W-1:0]  sqrt_v;
  logic [SIG_W-1:0]  sqrt_root;

  logic [SUM_W-1:0]  sum_rd, mag_c;
  logic [36:0]       q37, lim37, dvd37;
  logic [37:0]       q38, lim38, dvd38;
  logic [VAL_W-1:0]  q24, m_rd;
  logic [SIG_W-1:0]  sg_rd;
  logic [VAL_W:0]    diff25, a25;

  assign nf = (cfg_nf_q == '0) ? NF_W'(1) :
              (cfg_nf_q > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES) : cfg_nf_q;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign p          = in_i.payload;
  assign vmag       = p.feature_value[VAL_W-1] ? VAL_W'(-p.feature_value) : p.feature_value;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    val_d      = val_q;
    sq_d       = sq_q;
    feat_d     = feat_q;
    count_d    = count_q;
    n2_d       = n2_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    ssq_d      = ssq_q;
    p1_d       = p1_q;
    mean_d     = mean_q;
    sigma_d    = sigma_q;
    st_d       = st_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    acc_clr    = 1'b0;
    acc_we     = 1'b0;
    acc_re     = 1'b0;
    acc_waddr  = idx_q[AW-1:0];
    acc_raddr  = p.feature_index[AW-1:0];
    acc_wdata  = '0;
    stat_we    = 1'b0;
    stat_re    = 1'b0;
    stat_waddr = feat_q[AW-1:0];
    stat_raddr = p.feature_index[AW-1:0];
    stat_wdata = {mean_q, sigma_q};
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dsr    = '0;
    div_len    = '0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    sqrt_v     = div_quo[VAR_W-1:0];

    sum_rd = acc_rdata[AW_ACC-1:SSQ_W];
    mag_c  = sum_rd[SUM_W-1] ? SUM_W'(-sum_rd) : sum_rd;
    dvd37  = {1'b0, mag_c} + 37'(count_q[CNT_W-1:1]);
    q37    = div_quo[36:0];
    lim37  = neg_q ? 37'd8388608 : 37'd8388607;
    m_rd   = stat_rdata[AW_STAT-1:SIG_W];
    sg_rd  = stat_rdata[SIG_W-1:0];
    diff25 = {val_q[VAL_W-1], val_q} - {m_rd[VAL_W-1], m_rd};
    a25    = diff25[VAL_W] ? (VAL_W+1)'(-diff25) : diff25;
    dvd38  = {1'b0, a25, 12'b0} + 38'(sg_rd[SIG_W-1:1]);
    q38    = div_quo[37:0];
    lim38  = neg_q ? 38'd8388608 : 38'd8388607;
    q24    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d  = p.operation;
          idx_d = p.feature_index;
          val_d = p.feature_value;
          sq_d  = 48'({24'b0, vmag} * {24'b0, vmag});
          res_d = '{result_value: '0, result_sigma: '0, result_index: p.feature_index,
                    last_result: 1'b1, status: ST_OK};
          state_d = S_EMIT;
          unique case (p.operation)
            OP_CLEAR: begin
              acc_clr = 1'b1;
              count_d = '0;
              res_d.result_index = '0;
            end
            OP_ACCUM: begin
              if (p.example_usable) begin
                if (count_q >= CNT_W'(MAX_EXAMPLES)) begin
                  res_d.status = ST_COUNT_SAT;
                end else begin
                  if (p.last_element) begin
                    count_d = count_q + 1'b1;
                  end
                  if ({1'b0, p.feature_index} >= nf) begin
                    res_d.status = ST_RANGE;
                  end else begin
                    acc_re  = 1'b1;
                    state_d = S_ACC_WR;
                  end
                end
              end
            end
            OP_FINAL: begin
              feat_d  = '0;
              n2_d    = DSR_W'({12'b0, count_q} * {12'b0, count_q});
              state_d = S_FIN_RD;
            end
            OP_NORM: begin
              if ({1'b0, p.feature_index} >= nf) begin
                res_d.status = ST_RANGE;
              end else if (p.nominal_feature && !cfg_nnom_q) begin
                res_d.result_value = p.feature_value;
              end else begin
                stat_re = 1'b1;
                state_d = S_NRM_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ACC_WR: begin
        acc_we    = 1'b1;
        acc_wdata = {SUM_W'(sum_rd + {{(SUM_W-VAL_W){val_q[VAL_W-1]}}, val_q}),
                     SSQ_W'(acc_rdata[SSQ_W-1:0] + {12'b0, sq_q})};
        state_d   = S_EMIT;
      end
      S_FIN_RD: begin
        acc_re    = 1'b1;
        acc_raddr = feat_q[AW-1:0];
        state_d   = S_FIN_LOAD;
      end
      S_FIN_LOAD: begin
        st_d = ST_OK;
        if (count_q == '0) begin
          mean_d  = '0;
          sigma_d = '0;
          state_d = S_FIN_WR;
        end else begin
          neg_d     = sum_rd[SUM_W-1];
          mag_d     = mag_c;
          ssq_d     = acc_rdata[SSQ_W-1:0];
          div_start = 1'b1;
          div_dvd   = {dvd37, 35'b0};
          div_dsr   = {12'b0, count_q};
          div_len   = LEN_W'(37);
          state_d   = S_FIN_MEAN;
        end
      end
      S_FIN_MEAN: begin
        if (div_done) begin
          if (q37 > lim37) begin
            q24  = lim37[VAL_W-1:0];
            st_d = ST_OUT_SAT;
          end else begin
            q24 = q37[VAL_W-1:0];
          end
          mean_d    = neg_q ? VAL_W'(-q24) : q24;
          mul_start = 1'b1;
          mul_a     = {12'b0, ssq_q};
          mul_b     = {24'b0, count_q};
          state_d   = S_FIN_MUL1;
        end
      end
      S_FIN_MUL1: begin
        if (mul_done) begin
          p1_d      = mul_prod;
          mul_start = 1'b1;
          mul_a     = {36'b0, mag_q};
          mul_b     = mag_q;
          state_d   = S_FIN_MUL2;
        end
      end
      S_FIN_MUL2: begin
        if (mul_done) begin
          if (mul_prod > p1_q) begin
            sigma_d = '0;
            state_d = S_FIN_WR;
          end else begin
            div_start = 1'b1;
            div_dvd   = p1_q - mul_prod;
            div_dsr   = n2_q;
            div_len   = LEN_W'(PROD_W);
            state_d   = S_FIN_VDIV;
          end
        end
      end
      S_FIN_VDIV: begin
        if (div_done) begin
          if (div_quo[PROD_W-1:VAR_W] != '0) begin
            sigma_d = '1;
            st_d    = ST_OUT_SAT;
            state_d = S_FIN_WR;
          end else begin
            sqrt_start = 1'b1;
            state_d    = S_FIN_SQRT;
          end
        end
      end
      S_FIN_SQRT: begin
        if (sqrt_done) begin
          sigma_d = sqrt_root;
          state_d = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        stat_we = 1'b1;
        res_d   = '{result_value: mean_q, result_sigma: sigma_q,
                    result_index: feat_q[IDX_W-1:0],
                    last_result: (NF_W'(feat_q + 1'b1) == nf), status: st_q};
        state_d = S_EMIT;
      end
      S_NRM_LOAD: begin
        res_d.result_value = '0;
        res_d.status       = ST_OK;
        if (sg_rd == '0) begin
          state_d = S_EMIT;
        end else begin
          neg_d     = diff25[VAL_W];
          div_start = 1'b1;
          div_dvd   = {dvd38, 34'b0};
          div_dsr   = {1'b0, sg_rd};
          div_len   = LEN_W'(38);
          state_d   = S_NRM_DIV;
        end
      end
      S_NRM_DIV: begin
        if (div_done) begin
          if (q38 > lim38) begin
            q24          = lim38[VAL_W-1:0];
            res_d.status = ST_OUT_SAT;
          end else begin
            q24 = q38[VAL_W-1:0];
          end
          res_d.result_value = neg_q ? VAL_W'(-q24) : q24;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          if (op_q == OP_FINAL && !res_q.last_result) begin
            feat_d  = feat_q + 1'b1;
            state_d = S_FIN_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_vld_q  <= 1'b0;
      count_q    <= '0;
      feat_q     <= '0;
      cfg_nf_q   <= NF_W'(MAX_FEATURES);
      cfg_nnom_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      count_q   <= count_d;
      feat_q    <= feat_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUM_FEATURES: cfg_nf_q   <= cfg_data_i;
          CFG_NORM_NOMINAL: cfg_nnom_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    sq_q    <= sq_d;
    n2_q    <= n2_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    ssq_q   <= ssq_d;
    p1_q    <= p1_d;
    mean_q  <= mean_d;
    sigma_q <= sigma_d;
    st_q    <= st_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // sum and sum of squares per feature
  fzn_ram #(.W(AW_ACC), .DEPTH(MAX_FEATURES), .AW(AW)) u_acc_ram (
    .clk_i, .rst_ni,
    .clr_i(acc_clr), .we_i(acc_we), .waddr_i(acc_waddr), .wdata_i(acc_wdata),
    .re_i(acc_re), .raddr_i(acc_raddr), .rdata_o(acc_rdata)
  );

  // mean and sigma per feature, only reset clears them
  fzn_ram #(.W(AW_STAT), .DEPTH(MAX_FEATURES), .AW(AW)) u_stat_ram (
    .clk_i, .rst_ni,
    .clr_i(1'b0), .we_i(stat_we), .waddr_i(stat_waddr), .wdata_i(stat_wdata),
    .re_i(stat_re), .raddr_i(stat_raddr), .rdata_o(stat_rdata)
  );

  fzn_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dvd_i(div_dvd), .dsr_i(div_dsr),
    .len_i(div_len), .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  fzn_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .done_o(mul_done), .prod_o(mul_prod)
  );

  fzn_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .v_i(sqrt_v),
    .busy_o(sqrt_busy), .done_o(sqrt_done), .root_o(sqrt_root)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_EXAMPLES))
    else $error("example count beyond limit");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({div_busy, mul_busy, sqrt_busy}) <= 1)
    else $error("two arithmetic units busy at once");

  a_feat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN_RD |-> feat_q < nf)
    else $error("finalise feature beyond feature count");

  a_acc_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC_WR |-> $past(in_fire))
    else $error("accumulate write without an accepted beat");
`endif

endmodule

@@ hdl/fzn_ram.sv @@
// single-port-write, single-port-read memory with registered read data
// per-entry valid bits make unwritten or cleared entries read as zero
// no package dependencies
module fzn_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [W-1:0]     rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/fzn_div.sv @@
// serial restoring divider, one quotient bit a cycle
// dividend arrives msb-aligned, len gives the number of quotient bits
module fzn_div import fzn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dvd_i,
  input  logic [DSR_W-1:0]  dsr_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [PROD_W-1:0] quo_o
);

  logic              busy_q, busy_d, done_q, done_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [DSR_W:0]    rs;
  logic              ge;

  always_comb begin
    rs     = {rem_q, dvd_q[PROD_W-1]};
    ge     = rs >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = len_i;
      dvd_d  = dvd_i;
      rem_d  = '0;
      dsr_d  = dsr_i;
    end else if (busy_q) begin
      rem_d = ge ? DSR_W'(rs - {1'b0, dsr_q}) : rs[DSR_W-1:0];
      dvd_d = {dvd_q[PROD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == LEN_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

@@ hdl/fzn_mul.sv @@
// shift-add multiplier, one multiplier bit a cycle, stops when it runs out of bits
// depends on fzn_pkg for widths
module fzn_mul import fzn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] a_i,
  input  logic [MAG_W-1:0]  b_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  logic              busy_q, busy_d, done_q, done_d;
  logic [PROD_W-1:0] a_q, a_d, p_q, p_d;
  logic [MAG_W-1:0]  b_q, b_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (b_q[0]) begin
          p_d = p_q + a_q;
        end
        a_d = {a_q[PROD_W-2:0], 1'b0};
        b_d = {1'b0, b_q[MAG_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ hdl/fzn_sqrt.sv @@
// bit-pair integer square root, one root bit a cycle
// depends on fzn_pkg for widths
module fzn_sqrt import fzn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAR_W-1:0] v_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [SIG_W-1:0] root_o
);

  logic             busy_q, busy_d, done_q, done_d;
  logic [VAR_W-1:0] v_q, v_d, r_q, r_d, bit_q, bit_d, t;

  always_comb begin
    t      = r_q + bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = v_i;
      r_d    = '0;
      bit_d  = VAR_W'(1) << (VAR_W - 2);
    end else if (busy_q) begin
      if (v_q >= t) begin
        v_d = v_q - t;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[SIG_W-1:0];

endmodule

@@ tb/tb.sv @@
// self-checking bench for feature_zscore_normalizer_unit
// needs fzn_pkg, fzn_stream_if and the unit; a directed table, then random
// phases of clear, accumulate, finalise and normalise
module tb;
  import fzn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    bit         cfg;
    logic       cidx;
    logic [6:0] cdata;
    fzn_in_t    item;
    bit         typed;
    fzn_out_t   want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [NF_W-1:0] cfg_data_i = '0;

  fzn_stream_if #(.payload_t(fzn_in_t))  in_if ();
  fzn_stream_if #(.payload_t(fzn_out_t)) out_if ();

  feature_zscore_normalizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [SUM_W-1:0] acc_sum [64];
  logic [SSQ_W-1:0]        acc_sq [64];
  logic [CNT_W-1:0]        n_examples;
  logic signed [VAL_W-1:0] mean_tab [64];
  logic [SIG_W-1:0]        sigma_tab [64];
  logic [NF_W-1:0]         nf_reg;
  logic                    nom_reg;

  fzn_out_t expected_results [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned finalises = 0;
  int unsigned burst_left = 0;
  int unsigned cyc = 0;

  function automatic int unsigned live_features();
    if (nf_reg == 0) return 1;
    if (nf_reg > 64) return 64;
    return nf_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic fzn_out_t beat(logic [VAL_W-1:0] v, logic [SIG_W-1:0] s, int idx,
                                    bit last, status_e st);
    fzn_out_t o;
    o.result_value = v;
    o.result_sigma = s;
    o.result_index = idx[IDX_W-1:0];
    o.last_result  = last;
    o.status       = st;
    return o;
  endfunction

  task automatic finalise_stats();
    int unsigned nf;
    longint unsigned n, q, lim;
    logic [SUM_W-1:0] mag;
    logic [127:0] a, b, v;
    logic [SIG_W-1:0] sig;
    logic [VAL_W-1:0] mbits;
    status_e st;
    bit neg;
    nf = live_features();
    n = n_examples;
    for (int i = 0; i < nf; i++) begin
      st = ST_OK;
      if (n == 0) begin
        mean_tab[i] = '0;
        sigma_tab[i] = '0;
        expected_results.push_back(beat('0, '0, i, i + 1 == nf, ST_OK));
      end else begin
        neg = acc_sum[i][SUM_W-1];
        mag = neg ? -acc_sum[i] : acc_sum[i];
        q = (longint'(mag) + n / 2) / n;
        lim = neg ? 64'd8388608 : 64'd8388607;
        if (q > lim) begin
          q = lim;
          st = ST_OUT_SAT;
        end
        mbits = neg ? -q[VAL_W-1:0] : q[VAL_W-1:0];
        mean_tab[i] = mbits;
        a = 128'(n) * 128'(acc_sq[i]);
        b = 128'(mag) * 128'(mag);
        if (a < b) begin
          sig = '0;
        end else begin
          v = (a - b) / (128'(n) * 128'(n));
          if (v >= (128'd1 << VAR_W)) begin
            sig = 23'h7FFFFF;
            st = ST_OUT_SAT;
          end else begin
            sig = SIG_W'(int_sqrt(v[63:0]));
          end
        end
        sigma_tab[i] = sig;
        expected_results.push_back(beat(mbits, sig, i, i + 1 == nf, st));
      end
    end
  endtask

  task automatic predict_item(fzn_in_t it);
    int unsigned idx;
    logic [VAL_W-1:0] vmag;
    longint diff, x;
    longint unsigned a, q, lim, sg;
    status_e st;
    bit neg;
    idx = it.feature_index;
    vmag = it.feature_value[VAL_W-1] ? -it.feature_value : it.feature_value;
    case (it.operation)
      OP_CLEAR: begin
        foreach (acc_sum[i]) begin
          acc_sum[i] = '0;
          acc_sq[i] = '0;
        end
        n_examples = '0;
        expected_results.push_back(beat('0, '0, 0, 1'b1, ST_OK));
      end
      OP_ACCUM: begin
        st = ST_OK;
        if (it.example_usable) begin
          if (n_examples >= MAX_EXAMPLES) begin
            st = ST_COUNT_SAT;
          end else begin
            if (idx >= live_features()) begin
              st = ST_RANGE;
            end else begin
              acc_sum[idx] = acc_sum[idx] + SUM_W'(it.feature_value);
              acc_sq[idx] = acc_sq[idx] + SSQ_W'(48'(vmag) * 48'(vmag));
            end
            if (it.last_element) n_examples = n_examples + 1'b1;
          end
        end
        expected_results.push_back(beat('0, '0, idx, 1'b1, st));
      end
      OP_FINAL: begin
        finalises++;
        finalise_stats();
      end
      default: begin
        if (idx >= live_features()) begin
          expected_results.push_back(beat('0, '0, idx, 1'b1, ST_RANGE));
        end else if (it.nominal_feature && !nom_reg) begin
          expected_results.push_back(beat(it.feature_value, '0, idx, 1'b1, ST_OK));
        end else begin
          sg = sigma_tab[idx];
          st = ST_OK;
          q = 0;
          if (sg != 0) begin
            x = it.feature_value;
            diff = x - longint'(mean_tab[idx]);
            neg = diff < 0;
            a = longint'(neg ? -diff : diff) << 12;
            q = (a + sg / 2) / sg;
            lim = neg ? 64'd8388608 : 64'd8388607;
            if (q > lim) begin
              q = lim;
              st = ST_OUT_SAT;
            end
            if (neg) q = -q;
          end
          expected_results.push_back(beat(q[VAL_W-1:0], '0, idx, 1'b1, st));
        end
      end
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result side: compare each accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    fzn_out_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected beat, index", got.result_index, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.result_value !== want.result_value)
          report("result_value", got.result_value, want.result_value);
        if (got.result_sigma !== want.result_sigma)
          report("result_sigma", got.result_sigma, want.result_sigma);
        if (got.result_index !== want.result_index)
          report("result_index", got.result_index, want.result_index);
        if (got.last_result !== want.last_result)
          report("last_result", got.last_result, want.last_result);
        if (got.status !== want.status)
          report("status", got.status, want.status);
      end
    end
  end

  // receiver stalls in one of four randomly chosen styles; also the run limit
  always @(posedge clk_i) begin
    int unsigned mode;
    cyc++;
    if (cyc % 200 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2: out_if.ready <= ((cyc % 9) < 5);
      default: out_if.ready <= ($urandom_range(0, 1) != 0);
    endcase
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(fzn_in_t it, bit typed, fzn_out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    predict_item(it);
    if (typed) expected_results[expected_results.size() - 1] = want;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_FEATURES) nf_reg = data;
    else nom_reg = data[0];
  endtask

  function automatic fzn_in_t mk(op_e op, int idx, logic [VAL_W-1:0] v, bit u, bit l,
                                 bit nom);
    fzn_in_t it;
    it.operation       = op;
    it.feature_index   = idx[IDX_W-1:0];
    it.feature_value   = v;
    it.example_usable  = u;
    it.last_element    = l;
    it.nominal_feature = nom;
    return it;
  endfunction

  function automatic stim_row_t row(fzn_in_t it, bit typed, fzn_out_t want);
    stim_row_t r;
    r.cfg = 1'b0;
    r.cidx = 1'b0;
    r.cdata = '0;
    r.item = it;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [6:0] data);
    stim_row_t r;
    r = row(mk(OP_CLEAR, 0, '0, 0, 0, 0), 1'b0, beat('0, '0, 0, 1'b0, ST_OK));
    r.cfg = 1'b1;
    r.cidx = idx;
    r.cdata = data;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(logic [VAL_W-1:0] centre, int spread);
    if (spread < 0) return VAL_W'($urandom());
    return centre + VAL_W'($urandom_range(0, 2 * spread)) - VAL_W'(spread);
  endfunction

  initial begin
    stim_row_t table_rows [$];
    fzn_out_t none;
    logic [VAL_W-1:0] centre;
    int spread, nf, k;
    bit hole;

    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    none = beat('0, '0, 0, 1'b0, ST_OK);
    foreach (acc_sum[i]) begin
      acc_sum[i] = '0;
      acc_sq[i] = '0;
      mean_tab[i] = '0;
      sigma_tab[i] = '0;
    end
    n_examples = '0;
    nf_reg = 7'd64;
    nom_reg = 1'b0;

    // stats are zero after reset, so normalise gives 0 and nominal passes through
    table_rows.push_back(row(mk(OP_NORM, 5, 24'h000123, 0, 0, 0), 1,
                             beat('0, '0, 5, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_NORM, 7, 24'h800000, 0, 0, 1), 1,
                             beat(24'h800000, '0, 7, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_FINAL, 0, '0, 0, 0, 0), 0, none));
    table_rows.push_back(row(mk(OP_ACCUM, 3, 24'h7FFFFF, 0, 1, 0), 1,
                             beat('0, '0, 3, 1, ST_OK)));
    // two examples at the value extremes
    table_rows.push_back(row(mk(OP_ACCUM, 0, 24'h7FFFFF, 1, 0, 0), 1, beat('0, '0, 0, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 1, 24'h800000, 1, 0, 0), 1, beat('0, '0, 1, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 2, 24'h000000, 1, 0, 0), 1, beat('0, '0, 2, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 63, 24'h000ABC, 1, 1, 0), 1,
                             beat('0, '0, 63, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 0, 24'h800000, 1, 0, 0), 1, beat('0, '0, 0, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 1, 24'h800000, 1, 0, 0), 1, beat('0, '0, 1, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 2, 24'h000002, 1, 0, 0), 1, beat('0, '0, 2, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_ACCUM, 63, 24'hFFF000, 1, 1, 0), 1,
                             beat('0, '0, 63, 1, ST_OK)));
    table_rows.push_back(row(mk(OP_FINAL, 0, '0, 0, 0, 0), 0, none));
    table_rows.push_back(row(mk(OP_NORM, 0, 24'h000000, 0, 0, 0), 0, none));
    // sigma of one lsb: the quotient saturates both ways
    table_rows.push_back(row(mk(OP_NORM, 2, 24'h7FFFFF, 0, 0, 0), 0, none));
    table_rows.push_back(row(mk(OP_NORM, 2, 24'h800000, 0, 0, 0), 0, none));
    table_rows.push_back(row(mk(OP_NORM, 1, 24'h400000, 0, 0, 0), 0, none));
    table_rows.push_back(cfg_row(CFG_NUM_FEATURES, 7'd4));
    table_rows.push_back(cfg_row(CFG_NORM_NOMINAL, 7'd1));
    table_rows.push_back(row(mk(OP_NORM, 40, 24'h123456, 0, 0, 0), 1,
                             beat('0, '0, 40, 1, ST_RANGE)));
    // out-of-range element still closes its example
    table_rows.push_back(row(mk(OP_ACCUM, 50, 24'h001000, 1, 1, 0), 1,
                             beat('0, '0, 50, 1, ST_RANGE)));
    table_rows.push_back(row(mk(OP_NORM, 2, 24'h000001, 0, 0, 1), 0, none));
    table_rows.push_back(row(mk(OP_CLEAR, 9, 24'h7FFFFF, 1, 1, 1), 1,
                             beat('0, '0, 0, 1, ST_OK)));
    table_rows.push_back(cfg_row(CFG_NUM_FEATURES, 7'd0));
    table_rows.push_back(row(mk(OP_FINAL, 0, '0, 0, 0, 0), 0, none));
    table_rows.push_back(cfg_row(CFG_NUM_FEATURES, 7'd127));
    table_rows.push_back(row(mk(OP_FINAL, 0, '0, 0, 0, 0), 0, none));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[r]) begin
      if (table_rows[r].cfg) write_reg(table_rows[r].cidx, table_rows[r].cdata);
      else send_item(table_rows[r].item, table_rows[r].typed, table_rows[r].want);
    end

    // random phases: mostly well-formed examples, some noise
    while (items_sent < 420) begin
      case ($urandom_range(0, 9))
        0: write_reg(CFG_NUM_FEATURES, 7'($urandom_range(64, 127)));
        1: write_reg(CFG_NUM_FEATURES, 7'd0);
        default: write_reg(CFG_NUM_FEATURES, 7'($urandom_range(1, 8)));
      endcase
      write_reg(CFG_NORM_NOMINAL, 7'($urandom_range(0, 1)));
      nf = live_features();
      if ($urandom_range(0, 4) != 0)
        send_item(mk(OP_CLEAR, $urandom_range(0, 63), VAL_W'($urandom()), 0, 0, 0), 0, none);
      k = $urandom_range(1, (nf > 8) ? 2 : 6);
      for (int f = 0; f < nf; f++) begin
        centre = VAL_W'($urandom());
        case ($urandom_range(0, 3))
          0: spread = $urandom_range(0, 3);
          1: spread = $urandom_range(4, 4096);
          2: spread = -1;
          default: spread = $urandom_range(4096, 1 << 20);
        endcase
        mean_tab[f] = mean_tab[f];
        sigma_tab[f] = sigma_tab[f];
        for (int e = 0; e < k; e++) begin
          hole = ($urandom_range(0, 15) == 0);
          send_item(mk(OP_ACCUM, hole ? $urandom_range(0, 63) : f, pick_value(centre, spread),
                       $urandom_range(0, 9) != 0, (f == nf - 1) || hole,
                       1'($urandom_range(0, 1))), 0, none);
        end
      end
      send_item(mk(OP_FINAL, $urandom_range(0, 63), VAL_W'($urandom()),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1))), 0, none);
      repeat ($urandom_range(4, 12))
        send_item(mk(OP_NORM, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                     : $urandom_range(0, nf - 1), VAL_W'($urandom()),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 3) == 0), 0, none);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("sent %0d items, checked %0d result beats, %0d finalise passes",
             items_sent, results_seen, finalises);
    $display("covered value extremes, range errors, feature count limits and nominal passing");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", errors,
               expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
